>>> sv/ezr_pkg.sv
// Package for the ZYX Euler angle to rotation matrix core.
// Holds the CORDIC constants, the arctangent table and the shared widths.
// No dependencies.
`default_nettype none
package ezr_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 14;
    localparam int IO_BITS        = 16;
    localparam int CORDIC_STEPS   = 30;
    // CORDIC datapath width: Q2.30 values plus guard bits for overshoot.
    localparam int CW             = 34;
    localparam int ZW             = 32;
    localparam logic signed [CW-1:0] CORDIC_ONE_K = CW'(652032874);

    typedef logic signed [CW-1:0] t_cval;
    typedef logic signed [ZW-1:0] t_zval;

    function automatic t_zval atan_turn(input logic [4:0] idx);
        t_zval v;
        unique case (idx)
            5'd0:  v = 32'sh20000000;
            5'd1:  v = 32'sh12E4051E;
            5'd2:  v = 32'sh09FB385B;
            5'd3:  v = 32'sh051111D4;
            5'd4:  v = 32'sh028B0D43;
            5'd5:  v = 32'sh0145D7E1;
            5'd6:  v = 32'sh00A2F61E;
            5'd7:  v = 32'sh00517C55;
            5'd8:  v = 32'sh0028BE53;
            5'd9:  v = 32'sh00145F2F;
            5'd10: v = 32'sh000A2F98;
            5'd11: v = 32'sh000517CC;
            5'd12: v = 32'sh00028BE6;
            5'd13: v = 32'sh000145F3;
            5'd14: v = 32'sh0000A2FA;
            5'd15: v = 32'sh0000517D;
            5'd16: v = 32'sh000028BE;
            5'd17: v = 32'sh0000145F;
            5'd18: v = 32'sh00000A30;
            5'd19: v = 32'sh00000518;
            5'd20: v = 32'sh0000028C;
            5'd21: v = 32'sh00000146;
            5'd22: v = 32'sh000000A3;
            5'd23: v = 32'sh00000051;
            5'd24: v = 32'sh00000029;
            5'd25: v = 32'sh00000014;
            5'd26: v = 32'sh0000000A;
            5'd27: v = 32'sh00000005;
            5'd28: v = 32'sh00000003;
            5'd29: v = 32'sh00000001;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

>>> sv/ezr_if.sv
// Valid/ready channel interface used for the angle input and the matrix output.
// Depends on ezr_pkg for the field width.
`default_nettype none
interface ezr_angle_if;
    logic valid;
    logic ready;
    logic signed [ezr_pkg::IO_BITS-1:0] roll_angle;
    logic signed [ezr_pkg::IO_BITS-1:0] pitch_angle;
    logic signed [ezr_pkg::IO_BITS-1:0] yaw_angle;
    modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
    modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

interface ezr_matrix_if;
    logic valid;
    logic ready;
    logic signed [ezr_pkg::IO_BITS-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    input ready);
    modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    output ready);
endinterface
`default_nettype wire

>>> sv/ezr_cordic.sv
// Pipelined rotation CORDIC for three angles: one micro-rotation per stage.
// Depends on ezr_pkg. Produces quadrant-corrected cosine and sine in Q2.30.
`default_nettype none
module ezr_cordic #(
    parameter int ANGLE_BITS = ezr_pkg::ANGLE_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_en,
    input  wire logic                               i_valid,
    input  wire logic [3*ezr_pkg::IO_BITS-1:0]      i_angles,
    output      logic                               o_valid,
    output      ezr_pkg::t_cval                     o_cos [3],
    output      ezr_pkg::t_cval                     o_sin [3]
);
    localparam int NS = ezr_pkg::CORDIC_STEPS;
    localparam int IW = ezr_pkg::IO_BITS;

    ezr_pkg::t_cval r_x [NS+1][3];
    ezr_pkg::t_cval r_y [NS+1][3];
    ezr_pkg::t_zval r_z [NS+1][3];
    logic [1:0]     r_q [NS+1][3];
    logic [NS:0]    r_v;

    // Stage 0: fold each angle into a quadrant and a residual phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    for (genvar a = 0; a < 3; a++) begin : g_ang
        logic [ANGLE_BITS-1:0] w_ang;
        logic [31:0]           w_phase;
        assign w_ang   = ANGLE_BITS'(32'(signed'(i_angles[a*IW +: IW])));
        assign w_phase = {w_ang, (32-ANGLE_BITS)'(0)};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[0][a] <= ezr_pkg::CORDIC_ONE_K;
                r_y[0][a] <= '0;
                r_z[0][a] <= ezr_pkg::t_zval'({2'b00, w_phase[29:0]});
                r_q[0][a] <= w_phase[31:30];
            end
        end
    end

    for (genvar s = 0; s < NS; s++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else if (i_en) begin
                r_v[s+1] <= r_v[s];
            end
        end
        for (genvar a = 0; a < 3; a++) begin : g_lane
            ezr_pkg::t_cval w_xs, w_ys;
            assign w_xs = r_x[s][a] >>> s;
            assign w_ys = r_y[s][a] >>> s;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (!r_z[s][a][ezr_pkg::ZW-1]) begin
                        r_x[s+1][a] <= r_x[s][a] - w_ys;
                        r_y[s+1][a] <= r_y[s][a] + w_xs;
                        r_z[s+1][a] <= r_z[s][a] - ezr_pkg::atan_turn(5'(s));
                    end else begin
                        r_x[s+1][a] <= r_x[s][a] + w_ys;
                        r_y[s+1][a] <= r_y[s][a] - w_xs;
                        r_z[s+1][a] <= r_z[s][a] + ezr_pkg::atan_turn(5'(s));
                    end
                    r_q[s+1][a] <= r_q[s][a];
                end
            end
        end
    end

    // Quadrant correction stage.
    logic r_ov;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_ov <= r_v[NS];
        end
    end
    assign o_valid = r_ov;

    for (genvar a = 0; a < 3; a++) begin : g_quad
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                unique case (r_q[NS][a])
                    2'd0: begin o_cos[a] <= r_x[NS][a];  o_sin[a] <= r_y[NS][a];  end
                    2'd1: begin o_cos[a] <= -r_y[NS][a]; o_sin[a] <= r_x[NS][a];  end
                    2'd2: begin o_cos[a] <= -r_x[NS][a]; o_sin[a] <= -r_y[NS][a]; end
                    default: begin o_cos[a] <= r_y[NS][a]; o_sin[a] <= -r_x[NS][a]; end
                endcase
            end
        end
    end
endmodule
`default_nettype wire

>>> sv/ezr_matrix.sv
// Pipelined closed-form matrix products, rounding and saturation.
// Depends on ezr_pkg. Two product stages, one sum stage and one output stage.
`default_nettype none
module ezr_matrix #(
    parameter int FRAC_BITS = ezr_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_en,
    input  wire logic                                  i_valid,
    input  wire ezr_pkg::t_cval                        i_cos [3],
    input  wire ezr_pkg::t_cval                        i_sin [3],
    output      logic                                  o_valid,
    output      logic signed [ezr_pkg::IO_BITS-1:0]    o_m [9]
);
    localparam int CW = ezr_pkg::CW;
    localparam int PW = 2*CW;
    localparam int SH = 30 - FRAC_BITS;

    function automatic ezr_pkg::t_cval mul30(input ezr_pkg::t_cval a,
                                              input ezr_pkg::t_cval b);
        logic signed [PW-1:0] p;
        p = PW'(a) * PW'(b) + (PW'(1) <<< 29);
        return CW'(p >>> 30);
    endfunction

    function automatic logic signed [ezr_pkg::IO_BITS-1:0] to_out(
        input logic signed [CW:0] v);
        logic signed [CW:0] r;
        logic signed [CW:0] lim;
        lim = (CW+1)'(1) <<< FRAC_BITS;
        if (SH > 0) r = (v + ((CW+1)'(1) <<< (SH > 0 ? SH-1 : 0))) >>> SH;
        else        r = v;
        if (r > lim)  r = lim;
        if (r < -lim) r = -lim;
        return r[ezr_pkg::IO_BITS-1:0];
    endfunction

    // Stage A: first products (x=0, y=1, z=2).
    ezr_pkg::t_cval r_czcy, r_szcy, r_czsy, r_szsy, r_szcx, r_szsx, r_czcx, r_czsx;
    ezr_pkg::t_cval r_cysx, r_cycx, r_nsy, r_cx, r_sx;
    logic r_va, r_vb, r_vc;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0; r_vb <= 1'b0; r_vc <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid; r_vb <= r_va; r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_czcy <= mul30(i_cos[2], i_cos[1]);
            r_szcy <= mul30(i_sin[2], i_cos[1]);
            r_czsy <= mul30(i_cos[2], i_sin[1]);
            r_szsy <= mul30(i_sin[2], i_sin[1]);
            r_szcx <= mul30(i_sin[2], i_cos[0]);
            r_szsx <= mul30(i_sin[2], i_sin[0]);
            r_czcx <= mul30(i_cos[2], i_cos[0]);
            r_czsx <= mul30(i_cos[2], i_sin[0]);
            r_cysx <= mul30(i_cos[1], i_sin[0]);
            r_cycx <= mul30(i_cos[1], i_cos[0]);
            r_nsy  <= -i_sin[1];
            r_cx   <= i_cos[0];
            r_sx   <= i_sin[0];
        end
    end

    // Stage B: second products of the triple terms.
    ezr_pkg::t_cval r_t01, r_t02, r_t11, r_t12;
    ezr_pkg::t_cval r_b_czcy, r_b_szcy, r_b_szcx, r_b_szsx, r_b_czcx, r_b_czsx;
    ezr_pkg::t_cval r_b_cysx, r_b_cycx, r_b_nsy;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t01 <= mul30(r_czsy, r_sx);
            r_t02 <= mul30(r_czsy, r_cx);
            r_t11 <= mul30(r_szsy, r_sx);
            r_t12 <= mul30(r_szsy, r_cx);
            r_b_czcy <= r_czcy; r_b_szcy <= r_szcy; r_b_szcx <= r_szcx;
            r_b_szsx <= r_szsx; r_b_czcx <= r_czcx; r_b_czsx <= r_czsx;
            r_b_cysx <= r_cysx; r_b_cycx <= r_cycx; r_b_nsy  <= r_nsy;
        end
    end

    // Stage C: sums of the closed-form terms.
    logic signed [CW:0] r_s [9];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s[0] <= (CW+1)'(r_b_czcy);
            r_s[1] <= (CW+1)'(r_t01) - (CW+1)'(r_b_szcx);
            r_s[2] <= (CW+1)'(r_t02) + (CW+1)'(r_b_szsx);
            r_s[3] <= (CW+1)'(r_b_szcy);
            r_s[4] <= (CW+1)'(r_t11) + (CW+1)'(r_b_czcx);
            r_s[5] <= (CW+1)'(r_t12) - (CW+1)'(r_b_czsx);
            r_s[6] <= (CW+1)'(r_b_nsy);
            r_s[7] <= (CW+1)'(r_b_cysx);
            r_s[8] <= (CW+1)'(r_b_cycx);
        end
    end

    // Stage D: rounding and saturation into the output register.
    logic r_ov;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_ov <= r_vc;
        end
    end
    assign o_valid = r_ov;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 9; k++) begin
                o_m[k] <= to_out(r_s[k]);
            end
        end
    end

    // r_vc marks the sum stage; the pipe is A -> B -> C -> D.
endmodule
`default_nettype wire

>>> sv/euler_zyx_to_rotation_matrix_core.sv
// ZYX Euler angle to rotation matrix core, top level.
// Depends on ezr_pkg, ezr_if, ezr_cordic and ezr_matrix.
//
// Usage: the sink channel i_ang takes a triple of signed binary angles (roll
// about x, pitch about y, yaw about z; a full turn is 2^ANGLE_BITS). The
// source channel o_mat delivers the nine elements of R = Rz*Ry*Rx as signed
// Q1.FRAC_BITS values saturated to plus or minus one.
// A transfer happens on a rising edge where valid and ready are both high.
// The block is one deep pipeline: one stage folds the angle into a quadrant,
// thirty stages each perform one CORDIC micro-rotation for all three angles,
// one stage applies the quadrant, and the product network takes four more
// (first products, second products, sums, rounding and saturation into the
// output register). The pipeline can accept one new triple every cycle as
// long as the receiver keeps o_mat.ready high or the output slot is empty.
// When the receiver stalls, the whole pipeline holds in place, so i_ang.ready
// follows o_mat.ready or an empty output slot; nothing is lost or repeated.
// Synchronous active-low reset clears every valid bit; data registers keep
// whatever they hold.
`default_nettype none
module euler_zyx_to_rotation_matrix_core #(
    parameter int ANGLE_BITS = ezr_pkg::ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = ezr_pkg::FRAC_BITS_DEF
) (
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    ezr_angle_if.sink   i_ang,
    ezr_matrix_if.source o_mat
);
    logic           w_en;
    logic           w_cv;
    logic           w_mv;
    ezr_pkg::t_cval w_cos [3];
    ezr_pkg::t_cval w_sin [3];
    logic signed [ezr_pkg::IO_BITS-1:0] w_m [9];

    // The pipeline advances when the output slot is empty or being drained.
    assign w_en        = o_mat.ready || !w_mv;
    assign i_ang.ready = w_en;

    ezr_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_ang.valid),
        .i_angles ({i_ang.yaw_angle, i_ang.pitch_angle, i_ang.roll_angle}),
        .o_valid  (w_cv),
        .o_cos    (w_cos),
        .o_sin    (w_sin)
    );

    ezr_matrix #(.FRAC_BITS(FRAC_BITS)) u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_cv),
        .i_cos   (w_cos),
        .i_sin   (w_sin),
        .o_valid (w_mv),
        .o_m     (w_m)
    );

    assign o_mat.valid = w_mv;
    assign o_mat.m00 = w_m[0];
    assign o_mat.m01 = w_m[1];
    assign o_mat.m02 = w_m[2];
    assign o_mat.m10 = w_m[3];
    assign o_mat.m11 = w_m[4];
    assign o_mat.m12 = w_m[5];
    assign o_mat.m20 = w_m[6];
    assign o_mat.m21 = w_m[7];
    assign o_mat.m22 = w_m[8];
endmodule
`default_nettype wire

>>> tb/tb_euler_zyx_to_rotation_matrix_core.sv
// Testbench for the ZYX Euler angle to rotation matrix core.
// Depends on ezr_pkg, ezr_if and euler_zyx_to_rotation_matrix_core.
// It predicts each matrix from the angle triple and checks every element.
`default_nettype none
module tb_euler_zyx_to_rotation_matrix_core;

    localparam int LIMIT_CYCLES = 400000;
    localparam int LATENCY = 36;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
    } t_angles;

    typedef logic signed [15:0] t_elem;
    typedef t_elem t_matrix [9];

    logic i_clk;
    logic i_rst_n;
    ezr_angle_if  ang_ch ();
    ezr_matrix_if mat_ch ();

    euler_zyx_to_rotation_matrix_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ang   (ang_ch.sink),
        .o_mat   (mat_ch.source)
    );

    // Expected matrices, oldest first, one entry per element.
    t_elem matrices_due[$];
    int error_count;
    int cycle_count;
    // When set, neither side idles.
    bit no_idle;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Signed shift right by s with floor rounding.
    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    // Arctangent of 2^-i in units of 2^-32 turn.
    function automatic longint atan_table(int i);
        longint tbl [30] = '{
            'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43,
            'h0145D7E1, 'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F,
            'h000A2F98, 'h000517CC, 'h00028BE6, 'h000145F3, 'h0000A2FA,
            'h0000517D, 'h000028BE, 'h0000145F, 'h00000A30, 'h00000518,
            'h0000028C, 'h00000146, 'h000000A3, 'h00000051, 'h00000029,
            'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001};
        return tbl[i];
    endfunction

    // Cosine and sine in Q2.30 of a 16-bit binary angle, by rotation CORDIC.
    task automatic cordic_cos_sin(input logic signed [15:0] angle,
                                  output longint c, output longint s);
        logic [31:0] phase;
        longint x, y, z, nx, ny;
        int i;
        phase = {angle, 16'h0000};
        x = 652032874;
        y = 0;
        z = longint'(phase[29:0]);
        for (i = 0; i < ezr_pkg::CORDIC_STEPS; i++) begin
            if (z >= 0) begin
                nx = x - floor_shift(y, i);
                ny = y + floor_shift(x, i);
                z -= longint'(atan_table(i));
            end else begin
                nx = x + floor_shift(y, i);
                ny = y - floor_shift(x, i);
                z += longint'(atan_table(i));
            end
            x = nx;
            y = ny;
        end
        case (phase[31:30])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endtask

    function automatic longint q30_mul(longint a, longint b);
        return (a * b + (longint'(1) << 29)) >>> 30;
    endfunction

    // Round Q2.30 to Q1.14 half up, then clamp to plus or minus one.
    function automatic t_elem to_q14(longint v);
        longint r;
        r = (v + (longint'(1) << 15)) >>> 16;
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return t_elem'(r);
    endfunction

    task automatic predict_rotation(input t_angles a);
        longint cx, sx, cy, sy, cz, sz;
        cordic_cos_sin(a.roll, cx, sx);
        cordic_cos_sin(a.pitch, cy, sy);
        cordic_cos_sin(a.yaw, cz, sz);
        matrices_due.push_back(to_q14(q30_mul(cz, cy)));
        matrices_due.push_back(to_q14(q30_mul(q30_mul(cz, sy), sx) - q30_mul(sz, cx)));
        matrices_due.push_back(to_q14(q30_mul(q30_mul(cz, sy), cx) + q30_mul(sz, sx)));
        matrices_due.push_back(to_q14(q30_mul(sz, cy)));
        matrices_due.push_back(to_q14(q30_mul(q30_mul(sz, sy), sx) + q30_mul(cz, cx)));
        matrices_due.push_back(to_q14(q30_mul(q30_mul(sz, sy), cx) - q30_mul(cz, sx)));
        matrices_due.push_back(to_q14(-sy));
        matrices_due.push_back(to_q14(q30_mul(cy, sx)));
        matrices_due.push_back(to_q14(q30_mul(cy, cx)));
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    // Sends one angle triple, with a random gap first, and records its prediction.
    // Valid stays high after the transfer until the next gap or the end of the run.
    task automatic send_angles(input t_angles a);
        while (!no_idle && $urandom_range(99) < 23) begin
            ang_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        ang_ch.valid       <= 1'b1;
        ang_ch.roll_angle  <= a.roll;
        ang_ch.pitch_angle <= a.pitch;
        ang_ch.yaw_angle   <= a.yaw;
        @(posedge i_clk);
        while (!ang_ch.ready) @(posedge i_clk);
        predict_rotation(a);
    endtask

    // Output side: random stalls, and a check of every transfer.
    always @(posedge i_clk) begin
        t_matrix got;
        int k;
        if (i_rst_n) begin
            cycle_count <= cycle_count + 1;
            if (mat_ch.valid && mat_ch.ready) begin
                got = '{mat_ch.m00, mat_ch.m01, mat_ch.m02, mat_ch.m10, mat_ch.m11,
                        mat_ch.m12, mat_ch.m20, mat_ch.m21, mat_ch.m22};
                if (matrices_due.size() < 9) begin
                    report_mismatch("matrix arrived with none expected");
                end else begin
                    for (k = 0; k < 9; k++) begin
                        if (got[k] !== matrices_due[0])
                            report_mismatch($sformatf("element %0d: got %0d, expected %0d",
                                                      k, got[k], matrices_due[0]));
                        void'(matrices_due.pop_front());
                    end
                end
            end
        end
        mat_ch.ready <= no_idle || ($urandom_range(99) >= 23);
    end

    always @(posedge i_clk) begin
        if (cycle_count > LIMIT_CYCLES) begin
            report_mismatch("cycle limit reached");
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic test_directed();
        logic signed [15:0] corners [8] = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh4000,
                                           16'shC000, 16'sh0001, 16'shFFFF, 16'sh2000};
        int k;
        for (k = 0; k < 8; k++) begin
            send_angles('{corners[k], corners[(k + 3) % 8], corners[(k + 5) % 8]});
        end
        send_angles('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
        send_angles('{16'sh8000, 16'sh8000, 16'sh8000});
        send_angles('{16'sh1FFF, 16'sh3FFF, 16'sh5FFF});
        send_angles('{16'sh6000, 16'shA000, 16'shE000});
    endtask

    // Uniform random triples.
    task automatic test_random(input int n);
        int k;
        for (k = 0; k < n; k++)
            send_angles('{16'($urandom), 16'($urandom), 16'($urandom)});
    endtask

    // Angles near quadrant edges, where saturation and sign flips appear.
    task automatic test_quadrant_edges(input int n);
        int k;
        t_angles a;
        for (k = 0; k < n; k++) begin
            a.roll  = 16'($urandom_range(3) * 16384 + $urandom_range(8) - 4);
            a.pitch = 16'($urandom_range(3) * 16384 + $urandom_range(8) - 4);
            a.yaw   = 16'($urandom);
            send_angles(a);
        end
    endtask

    // Back-to-back transfers with no idling on either side.
    task automatic test_full_rate(input int n);
        no_idle = 1'b1;
        test_random(n);
        no_idle = 1'b0;
    endtask

    initial begin
        i_clk = 1'b0;
        error_count = 0;
        cycle_count = 0;
        no_idle = 1'b0;
        i_rst_n = 1'b0;
        ang_ch.valid = 1'b0;
        ang_ch.roll_angle = '0;
        ang_ch.pitch_angle = '0;
        ang_ch.yaw_angle = '0;
        mat_ch.ready = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(900);
        test_quadrant_edges(300);
        test_full_rate(300);
        test_random(100);
        ang_ch.valid <= 1'b0;
        while (matrices_due.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire
